FILE: hdl/del_pkg.sv
// ----------------------------------------------------------------------------
// del_pkg
// Types, codes and constants of the debounced event logger.
// ----------------------------------------------------------------------------
package del_pkg;

    localparam int DEF_RING_DEPTH = 2048;

    localparam logic [23:0] DEF_DEBOUNCE_US   = 24'd1000000;
    localparam logic [15:0] DEF_TEMP_PERIOD_S = 16'd600;
    localparam logic [1:0]  DEF_SOURCE_MODE   = 2'd0;
    localparam logic [19:0] US_PER_S          = 20'd1000000;
    localparam logic [15:0] DROP_MAX          = 16'hFFFF;

    localparam logic [1:0] REG_DEBOUNCE    = 2'd0;
    localparam logic [1:0] REG_TEMP_PERIOD = 2'd1;
    localparam logic [1:0] REG_SOURCE_MODE = 2'd2;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_EDGE  = 2'd1;
    localparam logic [1:0] CMD_TEMP  = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] SRC_MIC   = 2'd0;
    localparam logic [1:0] SRC_IR    = 2'd1;
    localparam logic [1:0] SRC_ACCEL = 2'd2;
    localparam logic [1:0] SRC_STOP  = 2'd3;

    localparam logic [1:0] MODE_IR    = 2'd0;
    localparam logic [1:0] MODE_ACCEL = 2'd1;

    localparam logic [1:0] KIND_NOISE  = 2'd0;
    localparam logic [1:0] KIND_MOTION = 2'd1;
    localparam logic [1:0] KIND_TEMP   = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_LOG  = 3'b010,
        PH_STOP = 3'b100
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [47:0]        now_us;
        logic [1:0]         source;
        logic [11:0]        mic_level;
        logic signed [15:0] temp_f_centi;
        logic [13:0]        humidity_centi;
        logic signed [15:0] heat_index_centi;
    } t_item;

    typedef struct packed {
        logic               entry_valid;
        logic [1:0]         event_kind;
        logic [47:0]        rel_time_us;
        logic signed [15:0] payload_a;
        logic signed [15:0] payload_b;
        logic signed [15:0] payload_c;
        logic               logged;
        logic               stop_accepted;
        logic               temp_due;
        logic               overflow_seen;
        logic [15:0]        dropped_count;
    } t_result;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] rel_time;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
    } t_record;

endpackage

FILE: hdl/debounced_event_logger.sv
// ----------------------------------------------------------------------------
// debounced_event_logger
// Timestamped sensor event recorder with a debounce per source and a ring
// memory that overwrites its oldest record when full.
//
//   channel   ports                                 handshake
//   command   i_item, start, busy                   beat when start & !busy
//   result    o_result, o_result_valid              one-cycle strobe, no stall
//   config    i_cfg_we, i_cfg_index, i_cfg_wdata    write when i_cfg_we
//
// A beat runs through capture with the ring read, read-modify-write
// of the ring and pointers, then the deadline compare. The result strobe
// follows in the cycle after the compare, while the next beat may already be taken.
// Reset is synchronous; the ring contents are not cleared, only pointers.
// The result side cannot stall; busy is the only hold on the command side.
// ----------------------------------------------------------------------------
module debounced_event_logger
    import del_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    output t_result     o_result,
    output logic        o_result_valid,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_wdata
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam logic [PW-1:0] LAST = PW'(RING_DEPTH - 1);

    t_state r_state;
    t_phase r_phase;
    t_item  r_item;
    t_result r_res;

    logic [23:0] r_debounce;
    logic [1:0]  r_mode;
    logic [47:0] r_period_us;
    logic [47:0] r_start_time;
    logic [47:0] r_deadline;
    logic [47:0] r_last [4];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic        r_overflow;
    logic [15:0] r_drops;

    t_record r_mem [RING_DEPTH];
    t_record r_rd;

    logic        w_accept;
    logic [35:0] w_period_prod;
    logic        w_enabled;
    logic [47:0] w_since;
    logic [47:0] w_rel;
    logic        w_push;
    t_record     w_rec;
    logic [PW-1:0] w_wnext;
    logic [PW-1:0] w_rnext;
    logic        w_full;
    logic        w_pop;
    logic        w_stop;
    logic        w_start;
    logic        w_set_deadline;
    t_result     n_res;
    t_result     n_out;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    assign w_period_prod = 36'(i_cfg_wdata[15:0]) * 36'(US_PER_S);

    always_comb begin
        case (r_item.source)
            SRC_IR:    w_enabled = (r_mode != MODE_ACCEL);
            SRC_ACCEL: w_enabled = (r_mode != MODE_IR);
            default:   w_enabled = 1'b1;
        endcase
    end

    assign w_since = r_item.now_us - r_last[r_item.source];
    assign w_rel   = r_item.now_us - r_start_time;
    assign w_wnext = (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
    assign w_rnext = (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
    assign w_full  = (w_wnext == r_rptr);

    always_comb begin
        w_push         = 1'b0;
        w_stop         = 1'b0;
        w_start        = 1'b0;
        w_set_deadline = 1'b0;
        w_pop          = 1'b0;
        w_rec          = '0;
        w_rec.rel_time = w_rel;
        n_res          = '0;
        if (r_state == ST_CALC) begin
            case (r_item.cmd)
                CMD_START: begin
                    if (r_phase == PH_IDLE) begin
                        w_start        = 1'b1;
                        w_set_deadline = 1'b1;
                    end
                end
                CMD_EDGE: begin
                    if (r_phase == PH_LOG && w_enabled && w_since > {24'b0, r_debounce}) begin
                        if (r_item.source == SRC_STOP) begin
                            w_stop = 1'b1;
                        end else begin
                            w_push = 1'b1;
                            if (r_item.source == SRC_MIC) begin
                                w_rec.kind = KIND_NOISE;
                                w_rec.a    = {4'b0, r_item.mic_level};
                            end else begin
                                w_rec.kind = KIND_MOTION;
                                w_rec.a    = {15'b0, (r_item.source == SRC_ACCEL)};
                            end
                        end
                    end
                end
                CMD_TEMP: begin
                    if (r_phase == PH_LOG) begin
                        w_push         = 1'b1;
                        w_set_deadline = 1'b1;
                        w_rec.kind     = KIND_TEMP;
                        w_rec.a        = r_item.temp_f_centi;
                        w_rec.b        = {2'b0, r_item.humidity_centi};
                        w_rec.c        = r_item.heat_index_centi;
                    end
                end
                default: begin
                    if (r_rptr != r_wptr) begin
                        w_pop             = 1'b1;
                        n_res.entry_valid = 1'b1;
                        n_res.event_kind  = r_rd.kind;
                        n_res.rel_time_us = r_rd.rel_time;
                        n_res.payload_a   = r_rd.a;
                        n_res.payload_b   = r_rd.b;
                        n_res.payload_c   = r_rd.c;
                    end
                end
            endcase
            n_res.logged        = w_push;
            n_res.stop_accepted = w_stop;
        end
    end

    always_comb begin
        n_out               = r_res;
        n_out.temp_due      = (r_phase == PH_LOG) && (r_item.now_us >= r_deadline);
        n_out.overflow_seen = r_overflow;
        n_out.dropped_count = r_drops;
    end

    // ring memory: read issued on the accept edge, write in the calc cycle
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_rec;
        end
        if (w_accept) begin
            r_rd <= r_mem[r_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
        if (r_state == ST_CALC) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_phase        <= PH_IDLE;
            r_debounce     <= DEF_DEBOUNCE_US;
            r_mode         <= DEF_SOURCE_MODE;
            r_period_us    <= 48'(36'(DEF_TEMP_PERIOD_S) * 36'(US_PER_S));
            r_start_time   <= '0;
            r_deadline     <= '0;
            r_last         <= '{default: '0};
            r_wptr         <= '0;
            r_rptr         <= '0;
            r_overflow     <= 1'b0;
            r_drops        <= '0;
            o_result_valid <= 1'b0;
            o_result       <= '0;
        end else begin
            o_result_valid <= (r_state == ST_DONE);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DEBOUNCE:    r_debounce  <= i_cfg_wdata;
                    REG_TEMP_PERIOD: r_period_us <= {12'b0, w_period_prod};
                    REG_SOURCE_MODE: r_mode      <= i_cfg_wdata[1:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    r_state <= ST_DONE;
                    if (w_start) begin
                        r_start_time <= r_item.now_us;
                        r_phase      <= PH_LOG;
                    end
                    if (w_set_deadline) begin
                        r_deadline <= r_item.now_us + r_period_us;
                    end
                    if (r_item.cmd == CMD_EDGE && (w_stop || w_push)) begin
                        r_last[r_item.source] <= r_item.now_us;
                    end
                    if (w_stop) begin
                        r_phase <= PH_STOP;
                    end
                    if (w_push) begin
                        r_wptr <= w_wnext;
                        if (w_full) begin
                            r_overflow <= 1'b1;
                            r_rptr     <= w_rnext;
                            if (r_drops != DROP_MAX) begin
                                r_drops <= r_drops + 1'b1;
                            end
                        end
                    end
                    if (w_pop) begin
                        r_rptr <= w_rnext;
                    end
                end
                ST_DONE: begin
                    r_state  <= ST_IDLE;
                    o_result <= n_out;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
